[sv/unsigned_to_decimal_ascii_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the decimal ASCII converter
// Shared shorthand for concurrent checks, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef UNSIGNED_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication.
`define U2DA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define U2DA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/u2da_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u2da_pkg
// Types and constants shared by the decimal ASCII converter.
// ---------------------------------------------------------------------------
package u2da_pkg;

   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam logic [7:0] MIN_CAPACITY = 8'd2;
   localparam logic [3:0] BCD_ADJ_MIN  = 4'd5;
   localparam logic [3:0] BCD_ADJ_ADD  = 4'd3;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NO_ROOM = 1'b1;

   typedef struct packed {
      logic [31:0] value;
      logic [7:0]  capacity;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
      logic       status;
   } rsp_type;

   // One classified item waiting for the back end.
   typedef struct packed {
      logic [31:0] value;
      logic [7:0]  capacity;
      logic        no_room;
   } job_type;

endpackage

[sv/unsigned_to_decimal_ascii_unit.sv]
`timescale 1ns / 1ps
// Converts an unsigned number to its decimal ASCII text, one character per
// response beat, most significant digit first, no leading zeros (zero gives
// a single '0'); the final digit carries last in place of a terminator. If
// capacity is below 2, or the digit count is not below capacity, a single
// beat with status no_room, character 0 and last set comes out instead.
// Only the low VALUE_BITS bits of value are converted. A request sits in
// a two-entry queue, so up to two more requests are taken while one
// converts. The back end dequeues, runs shift-add-3 over all VALUE_BITS
// input bits (one input bit per cycle), counts the digits, then emits the
// characters, each one waiting while the receiver holds the output
// register. A buffer too small for any text is rejected right after the
// dequeue, with no conversion; text that turns out too long is rejected
// after the digit count. Response beats leave from an output register
// that is refilled in the cycle it is taken.
// ---------------------------------------------------------------------------
// unsigned_to_decimal_ascii_unit
// Top level: front end, job queue and conversion back end.
// ---------------------------------------------------------------------------
module unsigned_to_decimal_ascii_unit import u2da_pkg::*; #(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    queue_full;
   logic    push;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head;

   // Take request beats and flag hopeless capacities up front.
   u2da_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   // Hold classified jobs so the front keeps accepting while the back works.
   u2da_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Convert, check fit, and drive response beats.
   u2da_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (head_valid),
      .job         (head),
      .job_pop     (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[sv/u2da_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u2da_queue
// Short job queue between the front end and the back end.
// ---------------------------------------------------------------------------
module u2da_queue import u2da_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[sv/u2da_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u2da_front
// Accepts request beats and flags those whose buffer cannot hold any text.
// ---------------------------------------------------------------------------
module u2da_front import u2da_pkg::*; (
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   input  logic    queue_full,
   output logic    push,
   output job_type push_job
);

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   // Flag a buffer too small for one digit plus terminator.
   always_comb begin
      push_job.value    = req_payload.value;
      push_job.capacity = req_payload.capacity;
      push_job.no_room  = (req_payload.capacity < MIN_CAPACITY);
   end

endmodule

[sv/u2da_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u2da_back
// Shift-add-3 conversion, digit count check and digit emission.
// ---------------------------------------------------------------------------
module u2da_back import u2da_pkg::*; #(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   // Decimal digits of 2**VALUE_BITS - 1 (1233/4096 approximates log10 2).
   localparam int NDIG  = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int BCD_W = 4 * NDIG;
   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam int IDX_W = $clog2(NDIG);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_MEASURE,
      ST_EMIT,
      ST_REJECT
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [7:0]            cap_ff, cap_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [BCD_W-1:0]      bcd_adj;
   logic [IDX_W-1:0]      msd;
   logic [IDX_W:0]        digit_count;
   logic [3:0]            cur_digit;
   logic                  out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Add 3 to every BCD digit of 5 or more before the shift.
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= BCD_ADJ_MIN) ?
                             bcd_ff[4*i +: 4] + BCD_ADJ_ADD : bcd_ff[4*i +: 4];
      end
   end

   // Find the most significant nonzero digit; zero keeps one digit.
   always_comb begin
      msd = '0;
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            msd = IDX_W'(i);
         end
      end
   end

   assign digit_count = {1'b0, msd} + 1'b1;
   assign cur_digit   = bcd_ff[{idx_ff, 2'b00} +: 4];

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      cap_in       = cap_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      job_pop      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               cap_in  = job.capacity;
               if (job.no_room) begin
                  state_in = ST_REJECT;
               end else begin
                  bin_in   = VALUE_BITS'(job.value);
                  bcd_in   = '0;
                  cnt_in   = CNT_W'(VALUE_BITS - 1);
                  state_in = ST_CONVERT;
               end
            end
         end
         ST_CONVERT: begin
            {bcd_in, bin_in} = {bcd_adj[BCD_W-2:0], bin_ff, 1'b0};
            cnt_in           = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_MEASURE;
            end
         end
         ST_MEASURE: begin
            // Text plus terminator must fit the buffer.
            if (8'(digit_count) >= cap_ff) begin
               state_in = ST_REJECT;
            end else begin
               idx_in   = msd;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.character = ASCII_ZERO + {4'd0, cur_digit};
               rsp_in.last      = (idx_ff == '0);
               rsp_in.status    = STATUS_OK;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         ST_REJECT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.character = '0;
               rsp_in.last      = 1'b1;
               rsp_in.status    = STATUS_NO_ROOM;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bin_ff       <= bin_in;
         bcd_ff       <= bcd_in;
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         idx_ff       <= idx_in;
         rsp_ff       <= rsp_in;
      end
   end

endmodule

[sv/u2da_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u2da_checker
// Port-level checks on the converter's request and response streams.
// ---------------------------------------------------------------------------
`include "unsigned_to_decimal_ascii_unit_assert.svh"

module u2da_checker import u2da_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // Hold a stalled request beat.
   `U2DA_ASSERT_NEXT(a_req_hold, clock, reset,
      req_valid && !req_ready,
      req_valid && $stable(req_payload),
      "request beat changed while stalled")

   // Hold a stalled response beat.
   `U2DA_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload),
      "response beat changed while stalled")

   // A refusal is a single beat with no character.
   `U2DA_ASSERT_IMPLY(a_no_room_form, clock, reset,
      rsp_valid && (rsp_payload.status == STATUS_NO_ROOM),
      rsp_payload.last && (rsp_payload.character == 8'd0),
      "malformed no_room beat")

   // Every ok beat carries a decimal digit.
   `U2DA_ASSERT_IMPLY(a_digit_range, clock, reset,
      rsp_valid && (rsp_payload.status == STATUS_OK),
      (rsp_payload.character >= ASCII_ZERO) && (rsp_payload.character <= ASCII_ZERO + 8'd9),
      "ok beat is not a digit")

   // Once a text has started, its next character follows right away.
   `U2DA_ASSERT_NEXT(a_text_unbroken, clock, reset,
      rsp_valid && rsp_ready && (rsp_payload.status == STATUS_OK) && !rsp_payload.last,
      rsp_valid && (rsp_payload.status == STATUS_OK),
      "text broken off before its last character")

endmodule

bind unsigned_to_decimal_ascii_unit u2da_checker u_checker (.*);

[bench/tb_unsigned_to_decimal_ascii_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for unsigned_to_decimal_ascii_unit
// Feeds number/capacity beats, spells each number out in decimal on the
// bench side and checks every response beat, field by field, in order.
// ---------------------------------------------------------------------------
module tb_unsigned_to_decimal_ascii_unit;
   import u2da_pkg::*;

   localparam int          RADIX        = 10;
   localparam int          MAX_DIGITS   = 10;    // 32-bit values
   localparam int          ITEMS_PER_PH = 140;   // random beats per load phase
   localparam int          HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int          DRAIN_CYCLES = 60;    // settling time after the last owed beat
   localparam int          STALL_LIMIT  = 2000;  // cycles without any handshake
   localparam logic [7:0]  NO_CHAR      = 8'h00;

   // Load phases of the random part.
   typedef enum logic [1:0] {
      PH_RX_SLOW,    // sender idles a little, receiver stalls a lot
      PH_TX_SLOW,    // the other way round
      PH_FULL_RATE   // no idling at all, plus one long receiver hold-off
   } load_phase_type;

   // One row of the directed table. When fixed is set, the single expected
   // beat is given in the row; otherwise the bench predictor supplies it.
   typedef struct packed {
      req_type req;
      logic    fixed;
      rsp_type want;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   rsp_type        pending_chars [$];   // characters still owed by the block
   dir_row_type    dir_table [$];
   load_phase_type load_phase;
   int             req_gap_pct;
   int             rsp_stall_pct;
   logic           hold_done;
   int             n_mismatch;
   int             quiet_cycles;

   unsigned_to_decimal_ascii_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -----------------------------------------------------------------------
   // Predictor: spell the number in decimal, most significant digit first,
   // or owe a single no_room beat when the text plus terminator won't fit.
   // -----------------------------------------------------------------------
   task automatic spell_decimal(input req_type r);
      logic [31:0] rest;
      logic [3:0]  lsd_first [MAX_DIGITS];
      int          n;
      rsp_type     beat;
      rest = r.value;
      n    = 0;
      if (r.capacity < MIN_CAPACITY) begin
         pending_chars.push_back('{character: NO_CHAR, last: 1'b1, status: STATUS_NO_ROOM});
         return;
      end
      // Peel digits off the low end; zero still yields one digit.
      do begin
         lsd_first[n] = 4'(rest % RADIX);
         rest         = rest / RADIX;
         n++;
      end while (rest != 0);
      if (n >= int'(r.capacity)) begin
         pending_chars.push_back('{character: NO_CHAR, last: 1'b1, status: STATUS_NO_ROOM});
         return;
      end
      for (int k = 0; k < n; k++) begin
         beat.character = ASCII_ZERO + 8'(lsd_first[n - 1 - k]);
         beat.last      = (k == n - 1);
         beat.status    = STATUS_OK;
         pending_chars.push_back(beat);
      end
   endtask

   // Rows whose answer is obvious carry it; the rest go to the predictor.
   function automatic dir_row_type known_row(input logic [31:0] v, input logic [7:0] cap,
                                             input logic [7:0] ch, input logic st);
      known_row.req  = '{value: v, capacity: cap};
      known_row.fixed = 1'b1;
      known_row.want = '{character: ch, last: 1'b1, status: st};
   endfunction

   function automatic dir_row_type open_row(input logic [31:0] v, input logic [7:0] cap);
      open_row.req   = '{value: v, capacity: cap};
      open_row.fixed = 1'b0;
      open_row.want  = '0;
   endfunction

   // Stimulus shaping only: how many decimal digits a value needs.
   function automatic int digit_count(input logic [31:0] v);
      digit_count = 1;
      while (v >= RADIX) begin
         v = v / RADIX;
         digit_count++;
      end
   endfunction

   function automatic logic [31:0] pow10(input int e);
      pow10 = 1;
      for (int i = 0; i < e; i++)
         pow10 = pow10 * RADIX;
   endfunction

   // Build a random request, biased toward capacities right at the edge of
   // fitting so that both the digit path and no_room are exercised hard.
   function automatic req_type pick_request();
      int          mode;
      int          d;
      int          n;
      logic [31:0] v;
      logic [7:0]  cap;
      mode = $urandom_range(9);
      if (mode <= 3) begin
         v = $urandom;
      end else if (mode <= 7) begin
         d = $urandom_range(9, 1);
         v = $urandom_range(pow10(d) - 1, pow10(d - 1));
      end else if (mode == 8) begin
         d = $urandom_range(9, 1);
         case ($urandom_range(2))
            0: v = pow10(d);
            1: v = pow10(d) - 1;
            default: v = 32'hFFFF_FFFF;
         endcase
      end else begin
         v = $urandom_range(20, 0);
      end
      n = digit_count(v);
      case ($urandom_range(9))
         0, 1:    cap = 8'($urandom_range(255, 0));
         2:       cap = 8'($urandom_range(1, 0));
         9:       cap = 8'($urandom_range(n, 2));
         default: cap = 8'(n + $urandom_range(3, 0));
      endcase
      pick_request = '{value: v, capacity: cap};
   endfunction

   // Present one request beat and hold it until the block takes it.
   // Returns at the edge where the beat was accepted.
   task automatic offer(input req_type r);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   function automatic void enter_phase(input load_phase_type ph);
      load_phase = ph;
      case (ph)
         PH_RX_SLOW: begin
            req_gap_pct   = 10;
            rsp_stall_pct = 52;
         end
         PH_TX_SLOW: begin
            req_gap_pct   = 52;
            rsp_stall_pct = 10;
         end
         default: begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end
      endcase
   endfunction

   // -----------------------------------------------------------------------
   // Stimulus: reset, directed table, then three random load phases.
   // -----------------------------------------------------------------------
   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      n_mismatch  = 0;
      hold_done   = 1'b0;
      enter_phase(PH_RX_SLOW);

      // Capacity below two: no_room whatever the value.
      dir_table.push_back(known_row(32'd0,          8'd0, NO_CHAR, STATUS_NO_ROOM));
      dir_table.push_back(known_row(32'd0,          8'd1, NO_CHAR, STATUS_NO_ROOM));
      dir_table.push_back(known_row(32'hFFFF_FFFF,  8'd0, NO_CHAR, STATUS_NO_ROOM));
      dir_table.push_back(known_row(32'hFFFF_FFFF,  8'd1, NO_CHAR, STATUS_NO_ROOM));
      // Single-digit values: zero gives a single '0', nine a single '9'.
      dir_table.push_back(known_row(32'd0,          8'd2, ASCII_ZERO, STATUS_OK));
      dir_table.push_back(known_row(32'd0,        8'd255, ASCII_ZERO, STATUS_OK));
      dir_table.push_back(known_row(32'd9,          8'd2, ASCII_ZERO + 8'd9, STATUS_OK));
      // Text too long: digit count not below capacity.
      dir_table.push_back(known_row(32'd10,         8'd2, NO_CHAR, STATUS_NO_ROOM));
      dir_table.push_back(known_row(32'hFFFF_FFFF, 8'd10, NO_CHAR, STATUS_NO_ROOM));
      dir_table.push_back(known_row(32'd999999999,  8'd9, NO_CHAR, STATUS_NO_ROOM));
      dir_table.push_back(known_row(32'd12345,      8'd5, NO_CHAR, STATUS_NO_ROOM));
      // Just fits, and plenty of room, up to the ten-digit maximum.
      dir_table.push_back(open_row(32'd10,          8'd3));
      dir_table.push_back(open_row(32'd12345,       8'd6));
      dir_table.push_back(open_row(32'd999999999,  8'd10));
      dir_table.push_back(open_row(32'd1000000000, 8'd11));
      dir_table.push_back(open_row(32'hFFFF_FFFF,  8'd11));
      dir_table.push_back(open_row(32'hFFFF_FFFF, 8'd255));
      dir_table.push_back(open_row(32'h8000_0000, 8'h80));
      dir_table.push_back(open_row(32'h5555_5555, 8'hAA));
      dir_table.push_back(open_row(32'hAAAA_AAAA, 8'h55));
      dir_table.push_back(open_row(32'd100,         8'd4));
      dir_table.push_back(open_row(32'd7,          8'h7F));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; owe either the typed beat or the predicted text.
      foreach (dir_table[i]) begin
         offer(dir_table[i].req);
         if (dir_table[i].fixed)
            pending_chars.push_back(dir_table[i].want);
         else
            spell_decimal(dir_table[i].req);
      end

      // Random part, one block of beats per load phase.
      for (int ph = 0; ph < 3; ph++) begin
         enter_phase(load_phase_type'(ph));
         repeat (ITEMS_PER_PH) begin
            req_type r;
            r = pick_request();
            offer(r);
            spell_decimal(r);
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every owed character, then let the block settle.
      while (pending_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (n_mismatch == 0)
         $display("PASS unsigned_to_decimal_ascii_unit");
      else
         $display("FAIL unsigned_to_decimal_ascii_unit");
      $finish;
   end

   // -----------------------------------------------------------------------
   // Receiver: random back-pressure per phase. On entering the full-rate
   // phase, hold ready low for a long stretch once so the job queue fills
   // and the block has to stall its request side.
   // -----------------------------------------------------------------------
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (load_phase == PH_FULL_RATE && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
            @(posedge clock);
         end
      end
   end

   // -----------------------------------------------------------------------
   // Checker: every response beat must match the oldest owed character.
   // -----------------------------------------------------------------------
   rsp_type owed;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_payload);
            n_mismatch++;
         end else begin
            owed = pending_chars.pop_front();
            if (rsp_payload.character !== owed.character) begin
               $display("%0t: character mismatch, expected %h actual %h",
                        $time, owed.character, rsp_payload.character);
               n_mismatch++;
            end
            if (rsp_payload.last !== owed.last) begin
               $display("%0t: last mismatch, expected %b actual %b",
                        $time, owed.last, rsp_payload.last);
               n_mismatch++;
            end
            if (rsp_payload.status !== owed.status) begin
               $display("%0t: status mismatch, expected %b actual %b",
                        $time, owed.status, rsp_payload.status);
               n_mismatch++;
            end
         end
      end
   end

   // Watchdog: drop out if no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL unsigned_to_decimal_ascii_unit");
            $finish;
         end
      end
   end

endmodule
